/* design/rme_pkg.sv */
// Shared types, constants and the microcode table of the register machine execute block.
package rme_pkg;

    localparam int WORD_W     = 32;
    localparam int OPC_LSB    = 28;
    localparam int RA_LSB     = 6;
    localparam int RB_LSB     = 3;
    localparam int RC_LSB     = 0;
    localparam int RIDX_W     = 3;
    localparam int IMM_REG_LSB = 25;
    localparam int IMM_W      = 25;
    localparam int RF_DEPTH   = 8;
    localparam int DIV_CNT_W  = 5;
    localparam int UPC_W      = 5;

    localparam logic [WORD_W-1:0] IMM_MASK = WORD_W'((1 << IMM_W) - 1);

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [RIDX_W-1:0] ridx_t;
    typedef logic [UPC_W-1:0]  uaddr_t;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_DIV   = 4'd3,
        OP_HALT  = 4'd4,
        OP_OUT   = 4'd5,
        OP_IN    = 4'd6,
        OP_LOAD  = 4'd7,
        OP_STORE = 4'd8,
        OP_BR    = 4'd9,
        OP_BRZ   = 4'd10,
        OP_BRNZ  = 4'd11,
        OP_NAND  = 4'd12,
        OP_OR    = 4'd13,
        OP_MOVE  = 4'd14,
        OP_LDI   = 4'd15
    } opcode_t;

    localparam logic [1:0] FLT_NONE = 2'd0;
    localparam logic [1:0] FLT_DIVZ = 2'd1;
    localparam logic [1:0] FLT_ADDR = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] instr_word;
        logic [WORD_W-1:0] io_in_value;
    } instr_data_t;

    typedef struct packed {
        logic [WORD_W-1:0] next_pc;
        logic              out_valid;
        logic [WORD_W-1:0] out_value;
        logic              halted_flag;
        logic [1:0]        fault_code;
    } result_data_t;

    typedef enum logic [0:0] { R1_NONE, R1_A } r1sel_t;

    typedef enum logic [3:0] {
        RES_NONE, RES_ADD, RES_SUB, RES_MUL, RES_DIV, RES_NAND,
        RES_OR, RES_MOVB, RES_IN, RES_MEM, RES_LDI
    } res_t;

    typedef enum logic [1:0] { W_NONE, W_A, W_C, W_IMM } wsel_t;
    typedef enum logic [1:0] { CHK_NONE, CHK_DIVZ, CHK_ADDR } chk_t;
    typedef enum logic [1:0] { M_NONE, M_RD, M_WR } memop_t;
    typedef enum logic [2:0] { PC_KEEP, PC_INC, PC_C, PC_AZ, PC_ANZ } pcsel_t;

    typedef struct packed {
        r1sel_t r1sel;
        res_t   res;
        wsel_t  wsel;
        chk_t   chk;
        memop_t mem;
        pcsel_t pcs;
        logic   div_go;
        logic   div_wait;
        logic   set_halt;
        logic   emit;
        logic   finish;
    } uword_t;

    localparam uword_t UW_NOP = '{r1sel: R1_NONE, res: RES_NONE, wsel: W_NONE,
                                  chk: CHK_NONE, mem: M_NONE, pcs: PC_KEEP,
                                  div_go: 1'b0, div_wait: 1'b0, set_halt: 1'b0,
                                  emit: 1'b0, finish: 1'b0};

    localparam uaddr_t UA_FETCH   = 5'd0;
    localparam uaddr_t UA_ADD     = 5'd1;
    localparam uaddr_t UA_SUB     = 5'd2;
    localparam uaddr_t UA_MUL1    = 5'd3;
    localparam uaddr_t UA_MUL2    = 5'd4;
    localparam uaddr_t UA_DIV1    = 5'd5;
    localparam uaddr_t UA_DIV2    = 5'd6;
    localparam uaddr_t UA_HALT    = 5'd7;
    localparam uaddr_t UA_OUT     = 5'd8;
    localparam uaddr_t UA_IN      = 5'd9;
    localparam uaddr_t UA_LD1     = 5'd10;
    localparam uaddr_t UA_LD2     = 5'd11;
    localparam uaddr_t UA_ST1     = 5'd12;
    localparam uaddr_t UA_ST2     = 5'd13;
    localparam uaddr_t UA_BR      = 5'd14;
    localparam uaddr_t UA_BRZ1    = 5'd15;
    localparam uaddr_t UA_BRZ2    = 5'd16;
    localparam uaddr_t UA_BRNZ1   = 5'd17;
    localparam uaddr_t UA_BRNZ2   = 5'd18;
    localparam uaddr_t UA_NAND    = 5'd19;
    localparam uaddr_t UA_OR      = 5'd20;
    localparam uaddr_t UA_MOVE    = 5'd21;
    localparam uaddr_t UA_LDI     = 5'd22;
    localparam uaddr_t UA_STOPPED = 5'd23;

    // Entry point of the routine for each opcode.
    function automatic uaddr_t dispatch(input opcode_t op);
        uaddr_t a;
        case (op)
            OP_ADD:   a = UA_ADD;
            OP_SUB:   a = UA_SUB;
            OP_MUL:   a = UA_MUL1;
            OP_DIV:   a = UA_DIV1;
            OP_HALT:  a = UA_HALT;
            OP_OUT:   a = UA_OUT;
            OP_IN:    a = UA_IN;
            OP_LOAD:  a = UA_LD1;
            OP_STORE: a = UA_ST1;
            OP_BR:    a = UA_BR;
            OP_BRZ:   a = UA_BRZ1;
            OP_BRNZ:  a = UA_BRNZ1;
            OP_NAND:  a = UA_NAND;
            OP_OR:    a = UA_OR;
            OP_MOVE:  a = UA_MOVE;
            OP_LDI:   a = UA_LDI;
            default:  a = UA_STOPPED;
        endcase
        return a;
    endfunction

    // Control store. Port 0 holds r[b] and port 1 holds r[c] after the fetch step,
    // unless a step rereads port 1 at a.
    function automatic uword_t ucode(input uaddr_t a);
        uword_t w;
        w = UW_NOP;
        case (a)
            UA_ADD:
            begin
                w.res = RES_ADD;  w.wsel = W_A; w.pcs = PC_INC; w.finish = 1'b1;
            end
            UA_SUB:
            begin
                w.res = RES_SUB;  w.wsel = W_A; w.pcs = PC_INC; w.finish = 1'b1;
            end
            UA_MUL1:
            begin
                w = UW_NOP;
            end
            UA_MUL2:
            begin
                w.res = RES_MUL;  w.wsel = W_A; w.pcs = PC_INC; w.finish = 1'b1;
            end
            UA_DIV1:
            begin
                w.chk = CHK_DIVZ; w.div_go = 1'b1;
            end
            UA_DIV2:
            begin
                w.div_wait = 1'b1;
                w.res = RES_DIV;  w.wsel = W_A; w.pcs = PC_INC; w.finish = 1'b1;
            end
            UA_HALT:
            begin
                w.set_halt = 1'b1; w.pcs = PC_INC; w.finish = 1'b1;
            end
            UA_OUT:
            begin
                w.emit = 1'b1; w.pcs = PC_INC; w.finish = 1'b1;
            end
            UA_IN:
            begin
                w.res = RES_IN; w.wsel = W_C; w.pcs = PC_INC; w.finish = 1'b1;
            end
            UA_LD1:
            begin
                w.chk = CHK_ADDR; w.mem = M_RD;
            end
            UA_LD2:
            begin
                w.res = RES_MEM; w.wsel = W_A; w.pcs = PC_INC; w.finish = 1'b1;
            end
            UA_ST1:
            begin
                w.chk = CHK_ADDR; w.r1sel = R1_A;
            end
            UA_ST2:
            begin
                w.mem = M_WR; w.pcs = PC_INC; w.finish = 1'b1;
            end
            UA_BR:
            begin
                w.pcs = PC_C; w.finish = 1'b1;
            end
            UA_BRZ1:
            begin
                w.r1sel = R1_A;
            end
            UA_BRZ2:
            begin
                w.pcs = PC_AZ; w.finish = 1'b1;
            end
            UA_BRNZ1:
            begin
                w.r1sel = R1_A;
            end
            UA_BRNZ2:
            begin
                w.pcs = PC_ANZ; w.finish = 1'b1;
            end
            UA_NAND:
            begin
                w.res = RES_NAND; w.wsel = W_A; w.pcs = PC_INC; w.finish = 1'b1;
            end
            UA_OR:
            begin
                w.res = RES_OR;   w.wsel = W_A; w.pcs = PC_INC; w.finish = 1'b1;
            end
            UA_MOVE:
            begin
                w.res = RES_MOVB; w.wsel = W_A; w.pcs = PC_INC; w.finish = 1'b1;
            end
            UA_LDI:
            begin
                w.res = RES_LDI;  w.wsel = W_IMM; w.pcs = PC_INC; w.finish = 1'b1;
            end
            UA_STOPPED:
            begin
                w.pcs = PC_KEEP; w.finish = 1'b1;
            end
            default:
            begin
                w = UW_NOP;
            end
        endcase
        return w;
    endfunction

endpackage

/* design/rme_stream_if.sv */
// Valid/ready channel that carries one payload per transfer.
interface rme_stream_if #(parameter type data_t = logic);

    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

/* design/rme_div.sv */
// Restoring unsigned divider that produces one quotient bit per cycle.
module rme_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [31:0] quotient
);
    import rme_pkg::*;

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(WORD_W - 1);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    word_t                rem_reg, rem_next;
    word_t                quo_reg, quo_next;
    word_t                dvs_reg, dvs_next;
    logic [WORD_W:0]      shifted;
    logic [WORD_W:0]      diff;
    logic                 bit_set;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[WORD_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        bit_set   = ~diff[WORD_W];
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = bit_set ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
            quo_next = {quo_reg[WORD_W-2:0], bit_set};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

/* design/register_machine_execute_top.sv */
// Top level of the register machine execute block: microcoded sequencer, register file and data memory.
// After reset the block sweeps the data memory to zero, one word per cycle, and takes no
// instruction until the sweep is done. An instruction then runs the fetch step plus one
// microcode step for add, sub, halt, out, in, br, nand, or, move and ldi; mul, load, store,
// brz and brnz run a further microcode step, since the product, the memory read data and the
// second register read are registered. A div starts the one-bit-per-cycle divider and waits
// while it is busy; a divide by zero reports its fault without starting the divider. The result
// waits in an output register, and the next instruction may be taken while it waits.
module register_machine_execute_top #(
    parameter int MEM_DEPTH = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    rme_stream_if.sink    instr,
    rme_stream_if.source  result
);
    import rme_pkg::*;

    localparam int ADDR_W = $clog2(MEM_DEPTH);
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MEM_DEPTH - 1);
    localparam word_t MEM_LIMIT = WORD_W'(MEM_DEPTH);

    uaddr_t       upc_reg, upc_next;
    word_t        pc_reg, pc_next;
    logic         halt_reg, halt_next;
    logic         out_vld_reg, out_vld_next;
    result_data_t out_data_reg, out_data_next;
    logic         clr_reg, clr_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;

    word_t        instr_reg;
    word_t        io_reg;
    word_t        p0_reg;
    word_t        p1_reg;
    word_t        prod_reg;
    word_t        mem_rd_reg;
    logic [RF_DEPTH-1:0] rf_vld_reg;

    word_t        rf_mem [RF_DEPTH];
    word_t        data_mem [MEM_DEPTH];

    uword_t       cw;
    logic         is_fetch;
    logic         take;
    logic         fault_divz;
    logic         fault_addr;
    logic         fault;
    logic         done;
    logic         stall;
    logic         step;
    logic         commit;
    logic         rd1_en;
    ridx_t        rd0_addr;
    ridx_t        rd1_addr;
    logic         rf_we;
    ridx_t        rf_wa;
    word_t        rf_wd;
    word_t        inc_pc;
    word_t        tgt_pc;
    logic [ADDR_W-1:0] mem_addr;
    logic         div_go;
    logic         div_busy;
    word_t        div_quo;

    rme_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go),
        .dividend (p0_reg),
        .divisor  (p1_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    always_comb
    begin
        cw         = ucode(upc_reg);
        is_fetch   = (upc_reg == UA_FETCH);
        instr.ready = is_fetch && !clr_reg;
        take       = instr.valid && instr.ready;
        fault_divz = !is_fetch && (cw.chk == CHK_DIVZ) && (p1_reg == '0);
        fault_addr = !is_fetch && (cw.chk == CHK_ADDR) && (p0_reg >= MEM_LIMIT);
        fault      = fault_divz || fault_addr;
        done       = !is_fetch && (cw.finish || fault);
        stall      = (done && out_vld_reg && !result.ready) || (cw.div_wait && div_busy);
        step       = !is_fetch && !stall;
        commit     = step && !fault;
        div_go     = commit && cw.div_go;
        mem_addr   = p0_reg[ADDR_W-1:0];

        rd0_addr = instr.data.instr_word[RB_LSB +: RIDX_W];
        rd1_addr = take ? instr.data.instr_word[RC_LSB +: RIDX_W]
                        : instr_reg[RA_LSB +: RIDX_W];
        rd1_en   = take || (step && (cw.r1sel == R1_A));

        case (cw.res)
            RES_ADD:  rf_wd = p0_reg + p1_reg;
            RES_SUB:  rf_wd = p0_reg - p1_reg;
            RES_MUL:  rf_wd = prod_reg;
            RES_DIV:  rf_wd = div_quo;
            RES_NAND: rf_wd = ~(p0_reg & p1_reg) & IMM_MASK;
            RES_OR:   rf_wd = p0_reg | p1_reg;
            RES_MOVB: rf_wd = p0_reg;
            RES_IN:   rf_wd = io_reg;
            RES_MEM:  rf_wd = mem_rd_reg;
            RES_LDI:  rf_wd = {{(WORD_W - IMM_W){1'b0}}, instr_reg[IMM_W-1:0]};
            default:  rf_wd = '0;
        endcase

        case (cw.wsel)
            W_A:     rf_wa = instr_reg[RA_LSB +: RIDX_W];
            W_C:     rf_wa = instr_reg[RC_LSB +: RIDX_W];
            W_IMM:   rf_wa = instr_reg[IMM_REG_LSB +: RIDX_W];
            default: rf_wa = '0;
        endcase
        rf_we = commit && (cw.wsel != W_NONE);

        inc_pc = pc_reg + 1'b1;
        tgt_pc = p1_reg + 1'b1;

        upc_next = upc_reg;
        if (take)
        begin
            upc_next = halt_reg ? UA_STOPPED
                                : dispatch(opcode_t'(instr.data.instr_word[OPC_LSB +: 4]));
        end
        else if (step)
        begin
            upc_next = done ? UA_FETCH : upc_reg + 1'b1;
        end

        pc_next = pc_reg;
        if (commit)
        begin
            case (cw.pcs)
                PC_INC:  pc_next = inc_pc;
                PC_C:    pc_next = tgt_pc;
                PC_AZ:   pc_next = (p0_reg == '0) ? tgt_pc : inc_pc;
                PC_ANZ:  pc_next = (p0_reg != '0) ? tgt_pc : inc_pc;
                default: pc_next = pc_reg;
            endcase
        end

        halt_next = halt_reg || (commit && cw.set_halt);

        out_data_next = out_data_reg;
        out_vld_next  = out_vld_reg && !result.ready;
        if (step && done)
        begin
            out_vld_next              = 1'b1;
            out_data_next.next_pc     = pc_next;
            out_data_next.out_valid   = commit && cw.emit;
            out_data_next.out_value   = (commit && cw.emit) ? p1_reg : '0;
            out_data_next.halted_flag = halt_next;
            out_data_next.fault_code  = fault_divz ? FLT_DIVZ :
                                        fault_addr ? FLT_ADDR : FLT_NONE;
        end

        clr_next     = clr_reg && (clr_cnt_reg != CLR_LAST);
        clr_cnt_next = clr_reg ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg     <= UA_FETCH;
            pc_reg      <= '0;
            halt_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
            rf_vld_reg  <= '0;
        end
        else
        begin
            upc_reg     <= upc_next;
            pc_reg      <= pc_next;
            halt_reg    <= halt_next;
            out_vld_reg <= out_vld_next;
            clr_reg     <= clr_next;
            clr_cnt_reg <= clr_cnt_next;
            if (rf_we)
            begin
                rf_vld_reg[rf_wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        prod_reg     <= p0_reg * p1_reg;
        if (take)
        begin
            instr_reg <= instr.data.instr_word;
            io_reg    <= instr.data.io_in_value;
        end
    end

    // Register file: one write and two registered reads per cycle.
    // An entry not written since reset reads as zero.
    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[rf_wa] <= rf_wd;
        end
        if (take)
        begin
            p0_reg <= rf_vld_reg[rd0_addr] ? rf_mem[rd0_addr] : '0;
        end
        if (rd1_en)
        begin
            p1_reg <= rf_vld_reg[rd1_addr] ? rf_mem[rd1_addr] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_reg)
        begin
            data_mem[clr_cnt_reg] <= '0;
        end
        else if (commit && (cw.mem == M_WR))
        begin
            data_mem[mem_addr] <= p1_reg;
        end
        if (commit && (cw.mem == M_RD))
        begin
            mem_rd_reg <= data_mem[mem_addr];
        end
    end

    assign result.valid = out_vld_reg;
    assign result.data  = out_data_reg;

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halted state was left");

    a_fault_keeps_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (step && fault) |=> $stable(pc_reg))
        else $error("pc changed on a faulting instruction");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_go |-> !div_busy)
        else $error("divider started while busy");

    a_clear_no_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> (upc_reg == UA_FETCH) && !rf_we)
        else $error("instruction in flight during memory clear");

endmodule
